// File: hdl/wavhp_pkg.sv
// package for the wav header parser: beat and result types, phase and status codes
// used by every module of the block, depends on nothing
`default_nettype none

package wavhp_pkg;

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 112;
  localparam int unsigned OutTuserW = 5;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagJunk = 32'h4B4E_554A;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagFllr = 32'h524C_4C46;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] BitsEight   = 16'd8;
  localparam logic [15:0] BitsSixteen = 16'd16;

  typedef enum logic [4:0] {
    ST_OK        = 5'd0,
    ST_END_RIFF  = 5'd1,
    ST_NO_RIFF   = 5'd2,
    ST_END_RSIZE = 5'd3,
    ST_END_WAVE  = 5'd4,
    ST_NO_WAVE   = 5'd5,
    ST_END_ID1   = 5'd6,
    ST_END_JSIZE = 5'd7,
    ST_END_JDATA = 5'd8,
    ST_END_ID2   = 5'd9,
    ST_NO_FMT    = 5'd10,
    ST_END_FSIZE = 5'd11,
    ST_END_FTAG  = 5'd12,
    ST_END_CHAN  = 5'd13,
    ST_END_RATE  = 5'd14,
    ST_END_AVG   = 5'd15,
    ST_END_ALIGN = 5'd16,
    ST_END_BITS  = 5'd17,
    ST_END_ID3   = 5'd18,
    ST_END_LSIZE = 5'd19,
    ST_END_LDATA = 5'd20,
    ST_END_ID4   = 5'd21,
    ST_NO_DATA   = 5'd22,
    ST_END_DSIZE = 5'd23,
    ST_BAD_CHAN  = 5'd24,
    ST_BAD_BITS  = 5'd25
  } status_e;

  typedef enum logic [18:0] {
    PH_RIFF  = 19'h00001,
    PH_RSIZE = 19'h00002,
    PH_WAVE  = 19'h00004,
    PH_ID1   = 19'h00008,
    PH_JSIZE = 19'h00010,
    PH_JDATA = 19'h00020,
    PH_ID2   = 19'h00040,
    PH_FSIZE = 19'h00080,
    PH_FTAG  = 19'h00100,
    PH_CHAN  = 19'h00200,
    PH_RATE  = 19'h00400,
    PH_AVG   = 19'h00800,
    PH_ALIGN = 19'h01000,
    PH_BITS  = 19'h02000,
    PH_ID3   = 19'h04000,
    PH_LSIZE = 19'h08000,
    PH_LDATA = 19'h10000,
    PH_ID4   = 19'h20000,
    PH_DSIZE = 19'h40000
  } phase_e;

  typedef struct packed {
    logic       end_of_stream;
    logic       start_of_file;
    logic [7:0] data_byte;
  } beat_t;

  typedef struct packed {
    logic [33:0] header_length;
    logic [31:0] sample_count;
    logic [4:0]  sample_bits;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    status_e     status;
  } result_t;

  function automatic status_e end_code(input phase_e ph);
    status_e code;
    unique case (ph)
      PH_RIFF:  code = ST_END_RIFF;
      PH_RSIZE: code = ST_END_RSIZE;
      PH_WAVE:  code = ST_END_WAVE;
      PH_ID1:   code = ST_END_ID1;
      PH_JSIZE: code = ST_END_JSIZE;
      PH_JDATA: code = ST_END_JDATA;
      PH_ID2:   code = ST_END_ID2;
      PH_FSIZE: code = ST_END_FSIZE;
      PH_FTAG:  code = ST_END_FTAG;
      PH_CHAN:  code = ST_END_CHAN;
      PH_RATE:  code = ST_END_RATE;
      PH_AVG:   code = ST_END_AVG;
      PH_ALIGN: code = ST_END_ALIGN;
      PH_BITS:  code = ST_END_BITS;
      PH_ID3:   code = ST_END_ID3;
      PH_LSIZE: code = ST_END_LSIZE;
      PH_LDATA: code = ST_END_LDATA;
      PH_ID4:   code = ST_END_ID4;
      PH_DSIZE: code = ST_END_DSIZE;
      default:  code = ST_END_RIFF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/wavhp_in_stage.sv
// input register of the wav header parser: one beat held for the parser
// depends on wavhp_pkg
`default_nettype none

module wavhp_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire wavhp_pkg::beat_t beat_i,
  input  wire logic           take_i,
  output logic                valid_o,
  output wavhp_pkg::beat_t    beat_o
);

  logic             valid_q, valid_d;
  wavhp_pkg::beat_t beat_q;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// File: hdl/wavhp_parse.sv
// header phase machine: field assembly, tag checks, skips and result forming
// depends on wavhp_pkg
`default_nettype none

module wavhp_parse (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire wavhp_pkg::beat_t beat_i,
  output logic                  res_valid_o,
  output wavhp_pkg::result_t    res_o
);

  wavhp_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [1:0]  idx_q, idx_d, cur_idx;
  logic [23:0] shift_q, shift_d, cur_shift;
  logic [32:0] skip_q, skip_d, skip_len;
  logic [31:0] rate_q, rate_d, cur_rate;
  logic [15:0] chan_q, chan_d, cur_chan;
  logic [15:0] bits_q, bits_d, cur_bits;
  logic [33:0] pos_q, pos_d, cur_pos;
  logic        done_q, done_d, cur_done;
  logic [31:0] field_v;
  logic        short_fld, last_byte;
  logic [1:0]  div_sh;

  // a start mark restarts the file with this beat as byte zero
  always_comb begin
    cur_phase = beat_i.start_of_file ? wavhp_pkg::PH_RIFF : phase_q;
    cur_idx   = beat_i.start_of_file ? 2'd0  : idx_q;
    cur_shift = beat_i.start_of_file ? 24'd0 : shift_q;
    cur_rate  = beat_i.start_of_file ? 32'd0 : rate_q;
    cur_chan  = beat_i.start_of_file ? 16'd0 : chan_q;
    cur_bits  = beat_i.start_of_file ? 16'd0 : bits_q;
    cur_pos   = beat_i.start_of_file ? 34'd0 : pos_q;
    cur_done  = beat_i.start_of_file ? 1'b0  : done_q;
  end

  assign field_v   = {8'd0, cur_shift} | (32'(beat_i.data_byte) << {cur_idx, 3'b000});
  assign short_fld = (cur_phase == wavhp_pkg::PH_FTAG) || (cur_phase == wavhp_pkg::PH_CHAN) ||
                     (cur_phase == wavhp_pkg::PH_ALIGN) || (cur_phase == wavhp_pkg::PH_BITS);
  assign last_byte = short_fld ? cur_idx[0] : (cur_idx == 2'd3);
  assign div_sh    = {1'b0, cur_bits == wavhp_pkg::BitsSixteen} + {1'b0, cur_chan == 16'd2};
  assign skip_len  = (cur_phase == wavhp_pkg::PH_JSIZE) ?
                     ({1'b0, field_v} + {32'd0, field_v[0]}) : {1'b0, field_v};

  always_comb begin
    phase_d     = cur_phase;
    idx_d       = cur_idx;
    shift_d     = cur_shift;
    skip_d      = skip_q;
    rate_d      = cur_rate;
    chan_d      = cur_chan;
    bits_d      = cur_bits;
    pos_d       = cur_pos;
    done_d      = cur_done;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = wavhp_pkg::ST_OK;

    if (!cur_done) begin
      if (beat_i.end_of_stream) begin
        res_valid_o  = 1'b1;
        res_o.status = wavhp_pkg::end_code(cur_phase);
        done_d       = 1'b1;
      end else begin
        pos_d = cur_pos + 34'd1;
        if ((cur_phase == wavhp_pkg::PH_JDATA) || (cur_phase == wavhp_pkg::PH_LDATA)) begin
          skip_d = skip_q - 33'd1;
          if (skip_q == 33'd1) begin
            phase_d = (cur_phase == wavhp_pkg::PH_JDATA) ? wavhp_pkg::PH_ID2
                                                         : wavhp_pkg::PH_ID4;
          end
        end else if (!last_byte) begin
          idx_d   = cur_idx + 2'd1;
          shift_d = field_v[23:0];
        end else begin
          idx_d   = 2'd0;
          shift_d = 24'd0;
          unique case (cur_phase)
            wavhp_pkg::PH_RIFF: begin
              if (field_v != wavhp_pkg::TagRiff) begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_RIFF;
                done_d       = 1'b1;
              end else begin
                phase_d = wavhp_pkg::PH_RSIZE;
              end
            end
            wavhp_pkg::PH_RSIZE: phase_d = wavhp_pkg::PH_WAVE;
            wavhp_pkg::PH_WAVE: begin
              if (field_v != wavhp_pkg::TagWave) begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_WAVE;
                done_d       = 1'b1;
              end else begin
                phase_d = wavhp_pkg::PH_ID1;
              end
            end
            wavhp_pkg::PH_ID1: begin
              if (field_v == wavhp_pkg::TagJunk) begin
                phase_d = wavhp_pkg::PH_JSIZE;
              end else if (field_v == wavhp_pkg::TagFmt) begin
                phase_d = wavhp_pkg::PH_FSIZE;
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_FMT;
                done_d       = 1'b1;
              end
            end
            wavhp_pkg::PH_JSIZE: begin
              skip_d  = skip_len;
              phase_d = (skip_len != 33'd0) ? wavhp_pkg::PH_JDATA : wavhp_pkg::PH_ID2;
            end
            wavhp_pkg::PH_ID2: begin
              if (field_v != wavhp_pkg::TagFmt) begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_FMT;
                done_d       = 1'b1;
              end else begin
                phase_d = wavhp_pkg::PH_FSIZE;
              end
            end
            wavhp_pkg::PH_FSIZE: phase_d = wavhp_pkg::PH_FTAG;
            wavhp_pkg::PH_FTAG:  phase_d = wavhp_pkg::PH_CHAN;
            wavhp_pkg::PH_CHAN: begin
              chan_d  = field_v[15:0];
              phase_d = wavhp_pkg::PH_RATE;
            end
            wavhp_pkg::PH_RATE: begin
              rate_d  = field_v;
              phase_d = wavhp_pkg::PH_AVG;
            end
            wavhp_pkg::PH_AVG:   phase_d = wavhp_pkg::PH_ALIGN;
            wavhp_pkg::PH_ALIGN: phase_d = wavhp_pkg::PH_BITS;
            wavhp_pkg::PH_BITS: begin
              bits_d  = field_v[15:0];
              phase_d = wavhp_pkg::PH_ID3;
            end
            wavhp_pkg::PH_ID3: begin
              if (field_v == wavhp_pkg::TagFllr) begin
                phase_d = wavhp_pkg::PH_LSIZE;
              end else if (field_v == wavhp_pkg::TagData) begin
                phase_d = wavhp_pkg::PH_DSIZE;
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_DATA;
                done_d       = 1'b1;
              end
            end
            wavhp_pkg::PH_LSIZE: begin
              skip_d  = skip_len;
              phase_d = (skip_len != 33'd0) ? wavhp_pkg::PH_LDATA : wavhp_pkg::PH_ID4;
            end
            wavhp_pkg::PH_ID4: begin
              if (field_v != wavhp_pkg::TagData) begin
                res_valid_o  = 1'b1;
                res_o.status = wavhp_pkg::ST_NO_DATA;
                done_d       = 1'b1;
              end else begin
                phase_d = wavhp_pkg::PH_DSIZE;
              end
            end
            wavhp_pkg::PH_DSIZE: begin
              res_valid_o = 1'b1;
              done_d      = 1'b1;
              if ((cur_chan != 16'd1) && (cur_chan != 16'd2)) begin
                res_o.status = wavhp_pkg::ST_BAD_CHAN;
              end else if ((cur_bits != wavhp_pkg::BitsEight) &&
                           (cur_bits != wavhp_pkg::BitsSixteen)) begin
                res_o.status = wavhp_pkg::ST_BAD_BITS;
              end else begin
                // divisor is 1, 2 or 4, so the count is a shift
                res_o.status        = wavhp_pkg::ST_OK;
                res_o.sample_rate   = cur_rate;
                res_o.channel_count = cur_chan[1:0];
                res_o.sample_bits   = cur_bits[4:0];
                res_o.sample_count  = field_v >> div_sh;
                res_o.header_length = pos_d;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PH_RIFF;
      idx_q   <= 2'd0;
      shift_q <= 24'd0;
      skip_q  <= 33'd0;
      rate_q  <= 32'd0;
      chan_q  <= 16'd0;
      bits_q  <= 16'd0;
      pos_q   <= 34'd0;
      done_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      skip_q  <= skip_d;
      rate_q  <= rate_d;
      chan_q  <= chan_d;
      bits_q  <= bits_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wavhp_out_stage.sv
// result register of the wav header parser, held until the receiver takes it
// depends on wavhp_pkg
`default_nettype none

module wavhp_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire wavhp_pkg::result_t res_i,
  output logic                    free_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output wavhp_pkg::result_t      res_o
);

  logic               valid_q, valid_d;
  wavhp_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: hdl/wav_header_parser.sv
// top level of the wav header parser: input register, phase machine, result register
// depends on wavhp_pkg, wavhp_in_stage, wavhp_parse and wavhp_out_stage
//
// usage
//   slave side takes the file one byte per beat: tdata is the byte, tuser marks
//   the first byte of a file, tlast marks the end of the stream (no byte then)
//   master side gives at most one beat per file: tuser is the status, tdata the
//   rate, channels, bits, sample count and header length (zero unless status ok)
//   one byte is taken every cycle while the receiver keeps up; each byte steps
//   the phase machine once, which sets the rate at one beat per cycle
//   a result is registered in the result register when its causing beat leaves the input register
//   after a result every beat is dropped until the next start-of-file mark
//   reset empties both registers and puts the parser at the start of a file
//   when the receiver stalls the result holds; one more beat waits in the
//   input register and then tready falls until the result is taken
`default_nettype none

module wav_header_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [wavhp_pkg::InTdataW-1:0]   s_axis_tdata,  // data_byte
  input  wire logic                             s_axis_tuser,  // start_of_file
  input  wire logic                             s_axis_tlast,  // end_of_stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // sample_rate, channel_count, sample_bits, sample_count, header_length, zero pad
  output logic [wavhp_pkg::OutTdataW-1:0]       m_axis_tdata,
  output logic [wavhp_pkg::OutTuserW-1:0]       m_axis_tuser   // status
);

  wavhp_pkg::beat_t   in_beat, held_beat;
  wavhp_pkg::result_t res_next, res_out;
  logic               held_valid, out_free, fire, res_valid;

  assign in_beat.data_byte     = s_axis_tdata;
  assign in_beat.start_of_file = s_axis_tuser;
  assign in_beat.end_of_stream = s_axis_tlast;

  assign fire = held_valid && out_free;

  wavhp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .beat_i  (in_beat),
    .take_i  (fire),
    .valid_o (held_valid),
    .beat_o  (held_beat)
  );

  wavhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .beat_i      (held_beat),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  wavhp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res_next),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tuser = res_out.status;
  assign m_axis_tdata = {7'd0, res_out.header_length, res_out.sample_count,
                         res_out.sample_bits, res_out.channel_count, res_out.sample_rate};

endmodule

`default_nettype wire

// File: hdl/wavhp_checker.sv
// port-level checks for the wav header parser, bound to the top level
// depends on wavhp_pkg and wav_header_parser
`default_nettype none

module wavhp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [wavhp_pkg::OutTdataW-1:0]  m_axis_tdata,
  input wire logic [wavhp_pkg::OutTuserW-1:0]  m_axis_tuser
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // no status beyond the bad bits code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= wavhp_pkg::ST_BAD_BITS))
    else $error("status out of range");

  // failures carry an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != wavhp_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("payload not cleared on failure");

  // success only with one or two channels of 8 or 16 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == wavhp_pkg::ST_OK) |->
      ((m_axis_tdata[33:32] == 2'd1) || (m_axis_tdata[33:32] == 2'd2)) &&
      ((m_axis_tdata[38:34] == 5'd8) || (m_axis_tdata[38:34] == 5'd16)))
    else $error("success with bad format");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/wavhp_checker.sv
`timescale 1ns / 1ps
// checker for the wav header parser: follows both stream channels, predicts each result
// from the accepted bytes and compares it field by field; depends on wavhp_pkg
module tb_wavhp_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [wavhp_pkg::InTdataW-1:0] s_axis_tdata,   // data_byte
  input  wire logic                           s_axis_tuser,   // start_of_file
  input  wire logic                           s_axis_tlast,   // end_of_stream
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // sample_rate, channel_count, sample_bits, sample_count, header_length, zero pad
  input  wire logic [wavhp_pkg::OutTdataW-1:0] m_axis_tdata,
  input  wire logic [wavhp_pkg::OutTuserW-1:0] m_axis_tuser,  // status
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         predicted_o,
  output logic [25:0]                         seen_status_o
);
  import wavhp_pkg::*;

  phase_e      phase;
  logic [1:0]  byte_idx;
  logic [31:0] word_acc;
  logic [32:0] skip_left;
  logic [31:0] rate_seen;
  logic [15:0] chans_seen;
  logic [15:0] bits_seen;
  logic [33:0] byte_pos;
  logic        answered;
  result_t     pending_results[$];

  function automatic int unsigned field_bytes(input phase_e ph);
    case (ph)
      PH_JDATA, PH_LDATA:                  return 1;
      PH_FTAG, PH_CHAN, PH_ALIGN, PH_BITS: return 2;
      default:                             return 4;
    endcase
  endfunction

  function automatic status_e end_status(input phase_e ph);
    case (ph)
      PH_RSIZE: return ST_END_RSIZE;
      PH_WAVE:  return ST_END_WAVE;
      PH_ID1:   return ST_END_ID1;
      PH_JSIZE: return ST_END_JSIZE;
      PH_JDATA: return ST_END_JDATA;
      PH_ID2:   return ST_END_ID2;
      PH_FSIZE: return ST_END_FSIZE;
      PH_FTAG:  return ST_END_FTAG;
      PH_CHAN:  return ST_END_CHAN;
      PH_RATE:  return ST_END_RATE;
      PH_AVG:   return ST_END_AVG;
      PH_ALIGN: return ST_END_ALIGN;
      PH_BITS:  return ST_END_BITS;
      PH_ID3:   return ST_END_ID3;
      PH_LSIZE: return ST_END_LSIZE;
      PH_LDATA: return ST_END_LDATA;
      PH_ID4:   return ST_END_ID4;
      PH_DSIZE: return ST_END_DSIZE;
      default:  return ST_END_RIFF;
    endcase
  endfunction

  task automatic restart_file();
    phase      = PH_RIFF;
    byte_idx   = '0;
    word_acc   = '0;
    skip_left  = '0;
    rate_seen  = '0;
    chans_seen = '0;
    bits_seen  = '0;
    byte_pos   = '0;
    answered   = 1'b0;
  endtask

  task automatic post_result(input status_e st, input logic [31:0] rate,
                             input logic [1:0] chans, input logic [4:0] bits,
                             input logic [31:0] count, input logic [33:0] hlen);
    result_t r;
    r.status        = st;
    r.sample_rate   = rate;
    r.channel_count = chans;
    r.sample_bits   = bits;
    r.sample_count  = count;
    r.header_length = hlen;
    pending_results.push_back(r);
    predicted_o = predicted_o + 1;
    answered = 1'b1;
  endtask

  task automatic reject(input status_e st);
    post_result(st, '0, '0, '0, '0, '0);
  endtask

  task automatic enter_skip(input logic [32:0] len, input phase_e skip_ph,
                            input phase_e next_ph);
    skip_left = len;
    phase = (len != '0) ? skip_ph : next_ph;
  endtask

  task automatic finish_field(input logic [31:0] v);
    logic [31:0] per_sample;
    case (phase)
      PH_RIFF:  if (v != TagRiff) reject(ST_NO_RIFF); else phase = PH_RSIZE;
      PH_RSIZE: phase = PH_WAVE;
      PH_WAVE:  if (v != TagWave) reject(ST_NO_WAVE); else phase = PH_ID1;
      PH_ID1: begin
        if (v == TagJunk) phase = PH_JSIZE;
        else if (v == TagFmt) phase = PH_FSIZE;
        else reject(ST_NO_FMT);
      end
      PH_JSIZE: enter_skip({1'b0, v} + 33'(v[0]), PH_JDATA, PH_ID2);
      PH_ID2:   if (v != TagFmt) reject(ST_NO_FMT); else phase = PH_FSIZE;
      PH_FSIZE: phase = PH_FTAG;
      PH_FTAG:  phase = PH_CHAN;
      PH_CHAN: begin
        chans_seen = v[15:0];
        phase = PH_RATE;
      end
      PH_RATE: begin
        rate_seen = v;
        phase = PH_AVG;
      end
      PH_AVG:   phase = PH_ALIGN;
      PH_ALIGN: phase = PH_BITS;
      PH_BITS: begin
        bits_seen = v[15:0];
        phase = PH_ID3;
      end
      PH_ID3: begin
        if (v == TagFllr) phase = PH_LSIZE;
        else if (v == TagData) phase = PH_DSIZE;
        else reject(ST_NO_DATA);
      end
      PH_LSIZE: enter_skip({1'b0, v}, PH_LDATA, PH_ID4);
      PH_ID4:   if (v != TagData) reject(ST_NO_DATA); else phase = PH_DSIZE;
      PH_DSIZE: begin
        if (chans_seen < 16'd1 || chans_seen > 16'd2) begin
          reject(ST_BAD_CHAN);
        end else if (bits_seen != BitsEight && bits_seen != BitsSixteen) begin
          reject(ST_BAD_BITS);
        end else begin
          per_sample = 32'(bits_seen >> 3) * 32'(chans_seen);
          post_result(ST_OK, rate_seen, chans_seen[1:0], bits_seen[4:0],
                      v / per_sample, byte_pos);
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sof, input logic eos);
    logic [31:0] v;
    if (sof) restart_file();
    if (answered) return;
    if (eos) begin
      reject(end_status(phase));
      return;
    end
    byte_pos = byte_pos + 34'd1;
    if (phase == PH_JDATA || phase == PH_LDATA) begin
      skip_left = skip_left - 33'd1;
      if (skip_left == '0) phase = (phase == PH_JDATA) ? PH_ID2 : PH_ID4;
      return;
    end
    word_acc = word_acc | (32'(b) << (8 * byte_idx));
    if (32'(byte_idx) + 1 < field_bytes(phase)) begin
      byte_idx = byte_idx + 2'd1;
      return;
    end
    v = word_acc;
    byte_idx = '0;
    word_acc = '0;
    finish_field(v);
  endtask

  task automatic check_result();
    result_t want;
    if (m_axis_tuser <= 5'd25) seen_status_o[m_axis_tuser] = 1'b1;
    if (pending_results.size() == 0) begin
      fail_count_o = fail_count_o + 1;
      if (fail_count_o <= 10)
        $display("unexpected result at %0t: status %0d", $time, m_axis_tuser);
      return;
    end
    want = pending_results.pop_front();
    if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.sample_rate ||
        m_axis_tdata[33:32] !== want.channel_count ||
        m_axis_tdata[38:34] !== want.sample_bits ||
        m_axis_tdata[70:39] !== want.sample_count ||
        m_axis_tdata[104:71] !== want.header_length) begin
      fail_count_o = fail_count_o + 1;
      if (fail_count_o <= 10) begin
        $display("mismatch at %0t: expected st %0d rate %h ch %0d bits %0d cnt %h len %h",
                 $time, want.status, want.sample_rate, want.channel_count,
                 want.sample_bits, want.sample_count, want.header_length);
        $display("  got st %0d rate %h ch %0d bits %0d cnt %h len %h",
                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[33:32],
                 m_axis_tdata[38:34], m_axis_tdata[70:39], m_axis_tdata[104:71]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_file();
      pending_results.delete();
      seen_status_o = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    pending_o = pending_results.size();
  end

endmodule

// File: tb/sv/tb_wav_header_parser.sv
`timescale 1ns / 1ps
// top of the wav header parser testbench: clock, reset, byte stimulus and verdict
// depends on wavhp_pkg, wav_header_parser and tb_wavhp_checker
module tb_wav_header_parser;
  import wavhp_pkg::*;

  localparam int unsigned ByteTarget   = 1550;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 16;

  typedef struct {
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] data_len;
    bit          has_junk;
    logic [31:0] junk_len;
    bit          has_fllr;
    logic [31:0] fllr_len;
  } wav_hdr_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned predicted;
  logic [25:0] seen_status;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          tx_calm;
  bit          rx_calm = 1'b0;
  logic [7:0]  file_q[$];
  bit          open_cut;

  wav_header_parser dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  tb_wavhp_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .predicted_o   (predicted),
    .seen_status_o (seen_status)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic sof, input logic eos,
                           input bit counted);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sof;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (counted) bytes_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic put32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q.push_back(v[8*k +: 8]);
  endtask

  task automatic put16(input logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic put_fill(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  // a chunk longer than 64 bytes is cut short, the file then ends inside it
  task automatic build_file(input wav_hdr_t hdr);
    file_q.delete();
    open_cut = 1'b0;
    put32(TagRiff);
    put32($urandom);
    put32(TagWave);
    if (hdr.has_junk) begin
      put32(TagJunk);
      put32(hdr.junk_len);
      if (hdr.junk_len > 64) begin
        put_fill($urandom_range(0, 6));
        open_cut = 1'b1;
        return;
      end
      put_fill(hdr.junk_len + 32'(hdr.junk_len[0]));
    end
    put32(TagFmt);
    put32(($urandom_range(0, 3) == 0) ? $urandom : 32'd16);
    put16(16'($urandom));
    put16(hdr.chans);
    put32(hdr.rate);
    put32($urandom);
    put16(16'($urandom));
    put16(hdr.bits);
    if (hdr.has_fllr) begin
      put32(TagFllr);
      put32(hdr.fllr_len);
      if (hdr.fllr_len > 64) begin
        put_fill($urandom_range(0, 6));
        open_cut = 1'b1;
        return;
      end
      put_fill(hdr.fllr_len);
    end
    put32(TagData);
    put32(hdr.data_len);
  endtask

  task automatic send_file(input bit with_sof, input bit with_eos);
    for (int k = 0; k < file_q.size(); k++)
      push_beat(file_q[k], with_sof && k == 0, 1'b0, 1'b1);
    if (with_eos) push_beat(8'($urandom), with_sof && file_q.size() == 0, 1'b1, 1'b1);
    files_sent++;
  endtask

  function automatic wav_hdr_t plain_header(input logic [15:0] chans, input logic [15:0] bits,
                                            input logic [31:0] rate, input logic [31:0] len);
    wav_hdr_t hdr;
    hdr.chans    = chans;
    hdr.bits     = bits;
    hdr.rate     = rate;
    hdr.data_len = len;
    hdr.has_junk = 1'b0;
    hdr.junk_len = '0;
    hdr.has_fllr = 1'b0;
    hdr.fllr_len = '0;
    return hdr;
  endfunction

  task automatic send_broken(input wav_hdr_t hdr, input int unsigned at,
                             input int unsigned keep);
    build_file(hdr);
    file_q[at] = file_q[at] ^ 8'($urandom_range(1, 255));
    while (file_q.size() > keep) void'(file_q.pop_back());
    send_file(1'b1, 1'b0);
  endtask

  function automatic wav_hdr_t random_header();
    wav_hdr_t hdr;
    bit       sane;
    sane = $urandom_range(0, 99) < 85;
    hdr.chans    = sane ? 16'($urandom_range(1, 2)) : 16'($urandom);
    sane = $urandom_range(0, 99) < 85;
    hdr.bits     = sane ? ($urandom_range(0, 1) ? BitsSixteen : BitsEight) : 16'($urandom);
    hdr.rate     = $urandom;
    hdr.data_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom;
    hdr.has_junk = $urandom_range(0, 3) == 0;
    hdr.junk_len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 9);
    hdr.has_fllr = $urandom_range(0, 3) == 0;
    hdr.fllr_len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 9);
    return hdr;
  endfunction

  task automatic random_file();
    int unsigned pick;
    int unsigned cut;
    int unsigned at;
    build_file(random_header());
    pick = $urandom_range(0, 99);
    if (open_cut) begin
      send_file(1'b1, 1'($urandom_range(0, 1)));
    end else if (pick < 50) begin
      send_file(1'b1, 1'b0);
      // trailing bytes and end marks after a result are dropped
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          push_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
    end else if (pick < 75) begin
      cut = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
      send_file(1'b1, 1'b1);
    end else if (pick < 87) begin
      at = $urandom_range(0, file_q.size() - 1);
      file_q[at] = file_q[at] ^ 8'($urandom_range(1, 255));
      send_file(1'b1, 1'b1);
    end else if (pick < 95) begin
      // no end mark, the next start mark restarts mid file
      cut = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
      send_file(1'b1, 1'b0);
    end else begin
      file_q.delete();
      put_fill($urandom_range(1, 12));
      send_file(1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    wav_hdr_t hdr;
    tx_calm = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes before any start mark
    build_file(plain_header(16'd1, BitsEight, 32'd8000, 32'd1000));
    send_file(1'b0, 1'b0);
    tx_calm = 1'b0;
    // start and end on one beat, then a dropped end mark
    file_q.delete();
    send_file(1'b1, 1'b1);
    push_beat(8'($urandom), 1'b0, 1'b1, 1'b0);

    hdr = plain_header(16'd2, BitsSixteen, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hdr.has_junk = 1'b1;
    hdr.junk_len = 32'd3;
    hdr.has_fllr = 1'b1;
    build_file(hdr);
    send_file(1'b1, 1'b0);
    hdr = plain_header(16'd1, BitsSixteen, 32'd0, 32'd0);
    hdr.has_junk = 1'b1;
    hdr.has_fllr = 1'b1;
    hdr.fllr_len = 32'd5;
    build_file(hdr);
    send_file(1'b1, 1'b0);

    hdr = plain_header(16'd2, BitsEight, 32'd44100, 32'd4096);
    send_broken(hdr, 0, 4);
    send_broken(hdr, 11, 12);
    send_broken(hdr, 15, 16);
    send_broken(hdr, 36, 40);
    hdr.has_junk = 1'b1;
    send_broken(hdr, 23, 24);
    hdr.has_junk = 1'b0;
    hdr.has_fllr = 1'b1;
    send_broken(hdr, 47, 48);

    build_file(plain_header(16'd0, BitsEight, 32'd1, 32'd1));
    send_file(1'b1, 1'b0);
    build_file(plain_header(16'd3, 16'd24, 32'd1, 32'd1));
    send_file(1'b1, 1'b0);
    build_file(plain_header(16'd2, 16'd24, 32'd1, 32'd1));
    send_file(1'b1, 1'b0);
    build_file(plain_header(16'hFFFF, 16'hFFFF, 32'd1, 32'd1));
    send_file(1'b1, 1'b0);
    build_file(plain_header(16'd1, 16'd0, 32'd1, 32'd1));
    send_file(1'b1, 1'b0);

    hdr = plain_header(16'd1, BitsEight, 32'd22050, 32'd10);
    hdr.has_junk = 1'b1;
    hdr.junk_len = 32'hFFFF_FFFF;
    build_file(hdr);
    send_file(1'b1, 1'b1);
    hdr.has_junk = 1'b0;
    hdr.has_fllr = 1'b1;
    hdr.fllr_len = 32'hFFFF_FFFE;
    build_file(hdr);
    send_file(1'b1, 1'b1);
    wait_drained();

    while (bytes_sent < ByteTarget) begin
      if (files_sent % 8 == 0) begin
        tx_calm = $urandom_range(0, 3) == 0;
        rx_calm <= $urandom_range(0, 3) == 0;
      end
      random_file();
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("run covered %0d file bytes in %0d files and %0d predicted results",
             bytes_sent, files_sent, predicted);
    $display("distinct status codes returned: %0d of 26", $countones(seen_status));
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
